@@ rtl/alle_pkg.sv @@
`default_nettype none
package alle_pkg;

  // Field widths of the stream payload.
  localparam int OP_W     = 2;
  localparam int VALUE_W  = 32;
  localparam int POS_W    = 4;
  localparam int STATUS_W = 2;
  localparam int LEN_W    = 5;

  // Operation codes.
  localparam logic [OP_W-1:0] OP_PREPEND = 2'd0;
  localparam logic [OP_W-1:0] OP_READ    = 2'd1;
  localparam logic [OP_W-1:0] OP_WRITE   = 2'd2;

  // Status codes.
  localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL   = 2'd1;
  localparam logic [STATUS_W-1:0] ST_BEYOND = 2'd2;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;   // latch a new input beat
    logic walk;     // execute one step of the operation or of the walk
    logic rd_done;  // value read from the node store is available
    logic finish;   // move the result into the output register
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic walk_end;  // the current step ends the walk or the operation
    logic need_rd;   // the step issues a value read that must be waited for
    logic out_free;  // the output register can take a result this cycle
  } sts_t;

endpackage
`default_nettype wire

@@ rtl/alle_ctrl.sv @@
`default_nettype none
module alle_ctrl (
  input  wire             clk,
  input  wire             rst,
  input  wire             in_valid,
  output logic            in_ready,
  input  alle_pkg::sts_t  sts,
  output alle_pkg::cmd_t  cmd
);
  import alle_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_WALK   = 4'b0010,
    S_RDWAIT = 4'b0100,
    S_FINISH = 4'b1000
  } state_t;

  state_t state, state_next;

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and command decode.
  always_comb begin
    state_next  = state;
    cmd         = '0;
    in_ready    = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_next = S_WALK;
        end
      end
      S_WALK: begin
        cmd.walk = 1'b1;
        if (sts.walk_end) begin
          state_next = sts.need_rd ? S_RDWAIT : S_FINISH;
        end
      end
      S_RDWAIT: begin
        cmd.rd_done = 1'b1;
        state_next  = S_FINISH;
      end
      S_FINISH: begin
        if (sts.out_free) begin
          cmd.finish = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

@@ rtl/alle_dp.sv @@
`default_nettype none
module alle_dp #(
  parameter int LIST_CAPACITY = 16
) (
  input  wire                              clk,
  input  wire                              rst,
  input  alle_pkg::cmd_t                   cmd,
  output alle_pkg::sts_t                   sts,
  input  wire  [alle_pkg::OP_W-1:0]        operation,
  input  wire  signed [alle_pkg::VALUE_W-1:0] value,
  input  wire  [alle_pkg::POS_W-1:0]       position,
  output logic                             out_valid,
  input  wire                              out_ready,
  output logic signed [alle_pkg::VALUE_W-1:0] read_value,
  output logic [alle_pkg::STATUS_W-1:0]    status,
  output logic [alle_pkg::LEN_W-1:0]       length
);
  import alle_pkg::*;

  // Link width holds every node index plus the "none" mark.
  localparam int LW = $clog2(LIST_CAPACITY + 1);
  localparam int IW = $clog2(LIST_CAPACITY);
  localparam logic [LW-1:0] NONE = LW'(LIST_CAPACITY);

  // Node store: one write and one registered read per cycle on each array.
  logic signed [VALUE_W-1:0] value_mem [LIST_CAPACITY];
  logic [LW-1:0]             next_mem  [LIST_CAPACITY];

  logic [OP_W-1:0]           op_q;
  logic signed [VALUE_W-1:0] val_q;
  logic [POS_W-1:0]          steps;
  logic                      use_head;
  logic [LW-1:0]             head;
  logic [LW-1:0]             count;
  logic [LW-1:0]             link_q;
  logic signed [VALUE_W-1:0] value_q;
  logic signed [VALUE_W-1:0] res_value;
  logic [STATUS_W-1:0]       res_status;

  logic [LW-1:0] ptr;
  logic          ptr_valid;
  logic          full;
  logic          is_walk;
  logic          at_target;
  logic          prep_en;
  logic          vwrite;
  logic          vread;
  logic          lread;
  logic [IW-1:0] vwaddr;

  // Nodes are taken from the free list in index order and never returned,
  // so the free head always equals the entry count.
  always_comb begin
    ptr       = use_head ? head : link_q;
    ptr_valid = (ptr != NONE);
    full      = (count == NONE);
    is_walk   = (op_q == OP_READ) || (op_q == OP_WRITE);
    at_target = ptr_valid && (steps == '0);
    prep_en   = cmd.walk && (op_q == OP_PREPEND) && !full;
    vwrite    = prep_en || (cmd.walk && (op_q == OP_WRITE) && at_target);
    vread     = cmd.walk && (op_q == OP_READ) && at_target;
    lread     = cmd.walk && is_walk && ptr_valid && (steps != '0);
    vwaddr    = prep_en ? count[IW-1:0] : ptr[IW-1:0];
    sts.walk_end = !is_walk || !ptr_valid || (steps == '0);
    sts.need_rd  = (op_q == OP_READ) && at_target;
    sts.out_free = !out_valid || out_ready;
  end

  // Value array.
  always_ff @(posedge clk) begin
    if (vwrite) begin
      value_mem[vwaddr] <= val_q;
    end
    if (vread) begin
      value_q <= value_mem[ptr[IW-1:0]];
    end
  end

  // Next-link array; the read data register drives the walk pointer.
  always_ff @(posedge clk) begin
    if (prep_en) begin
      next_mem[count[IW-1:0]] <= head;
    end
    if (lread) begin
      link_q <= next_mem[ptr[IW-1:0]];
    end
  end

  // Input latch and walk step counter.
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      op_q  <= operation;
      val_q <= value;
      steps <= position;
    end else if (lread) begin
      steps <= steps - 1'b1;
    end
  end

  // Head selection for the first walk step.
  always_ff @(posedge clk) begin
    if (rst) begin
      use_head <= 1'b0;
    end else if (cmd.accept) begin
      use_head <= 1'b1;
    end else if (lread) begin
      use_head <= 1'b0;
    end
  end

  // List head and entry count.
  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= NONE;
      count <= '0;
    end else if (prep_en) begin
      head  <= count;
      count <= count + 1'b1;
    end
  end

  // Result assembly.
  always_ff @(posedge clk) begin
    if (cmd.walk) begin
      res_value <= '0;
      case (op_q)
        OP_PREPEND: res_status <= full ? ST_FULL : ST_OK;
        OP_READ, OP_WRITE: res_status <= ptr_valid ? ST_OK : ST_BEYOND;
        default: res_status <= ST_OK;
      endcase
    end else if (cmd.rd_done) begin
      res_value <= value_q;
    end
  end

  // Output register, which frees the input side while a result waits.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.finish) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      read_value <= res_value;
      status     <= res_status;
      length     <= LEN_W'(count);
    end
  end

endmodule
`default_nettype wire

@@ rtl/array_linked_list_engine_top.sv @@
`default_nettype none
// Singly linked list held in a store of LIST_CAPACITY nodes, with one
// result beat for every input beat. Operations are prepend, read at a list
// position and write at a list position. The block takes one operation at
// a time. A read or write at position p walks min(p, n) next links on a
// list of n entries, as the walk stops at the list end; a read that finds
// its node then passes through a read-wait state. The walk follows one next
// link per cycle through the registered read port of the link array. A new
// input beat is taken while the previous result still waits in the output
// register. No clearing pass runs after reset.
module array_linked_list_engine_top #(
  parameter int LIST_CAPACITY = 16
) (
  input  wire         clk,
  input  wire         rst,
  input  wire         s_axis_tvalid,
  output logic        s_axis_tready,
  input  wire  [39:0] s_axis_tdata,   // value[31:0], position[35:32], zero fill
  input  wire  [1:0]  s_axis_tuser,   // operation[1:0]
  output logic        m_axis_tvalid,
  input  wire         m_axis_tready,
  output logic [39:0] m_axis_tdata,   // read_value[31:0], length[36:32], zero fill
  output logic [1:0]  m_axis_tuser    // status[1:0]
);
  import alle_pkg::*;

  cmd_t cmd;
  sts_t sts;

  logic signed [VALUE_W-1:0] read_value;
  logic [STATUS_W-1:0]       status;
  logic [LEN_W-1:0]          length;

  alle_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  alle_dp #(
    .LIST_CAPACITY (LIST_CAPACITY)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .sts        (sts),
    .operation  (s_axis_tuser),
    .value      (s_axis_tdata[31:0]),
    .position   (s_axis_tdata[35:32]),
    .out_valid  (m_axis_tvalid),
    .out_ready  (m_axis_tready),
    .read_value (read_value),
    .status     (status),
    .length     (length)
  );

  // Pack the result fields onto the output stream.
  assign m_axis_tdata = {3'b000, length, read_value};
  assign m_axis_tuser = status;

endmodule
`default_nettype wire

@@ rtl/alle_checker.sv @@
`default_nettype none
module alle_checker #(
  parameter int LIST_CAPACITY = 16
) (
  input wire        clk,
  input wire        rst,
  input wire        s_axis_tvalid,
  input wire        s_axis_tready,
  input wire        m_axis_tvalid,
  input wire        m_axis_tready,
  input wire [39:0] m_axis_tdata,
  input wire [1:0]  m_axis_tuser
);
  import alle_pkg::*;

  // One operation at a time: the input closes after each accepted beat.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input accepted while an operation is in progress");

  // A result beat with an error status reports a zero value.
  a_zero_on_error: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && (m_axis_tuser != ST_OK) |-> (m_axis_tdata[31:0] == 32'd0))
    else $error("nonzero read value with error status");

  // The store is full only when the list holds every node.
  a_full_length: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && (m_axis_tuser == ST_FULL)
    |-> (m_axis_tdata[36:32] == LEN_W'(LIST_CAPACITY)))
    else $error("full status with list shorter than capacity");

  // The reported length never exceeds the capacity.
  a_length_bound: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && (LIST_CAPACITY < 32)
    |-> (32'(m_axis_tdata[36:32]) <= LIST_CAPACITY))
    else $error("length beyond capacity");

  // A stalled result beat holds.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready
    |=> m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("result beat changed while stalled");

endmodule

bind array_linked_list_engine_top alle_checker #(
  .LIST_CAPACITY (LIST_CAPACITY)
) u_alle_checker (.*);
`default_nettype wire
